### rtl/core/signed_binary_to_decimal_ascii_top_assert.svh
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_top_assert.svh
// assertion macros used by the decimal text converter
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

`ifndef SYNTH
`define SBDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SBDA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// constants and types of the signed binary to decimal text converter
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int VALUE_W    = 32;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } cell_ctrl_t;

endpackage

### rtl/core/sbda_cell.sv
// ----------------------------------------------------------------------------
// sbda_cell
// one decimal digit cell: shift-add-3 conversion step and digit shift-out
// ----------------------------------------------------------------------------
module sbda_cell
  import sbda_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               bit_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic               bit_out,
  output logic [DIGIT_W-1:0] digit_out
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  assign adj       = (digit_r >= ADJ_LIMIT) ? digit_r + ADJ_ADD : digit_r;
  assign bit_out   = adj[DIGIT_W-1];
  assign digit_out = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

### rtl/core/signed_binary_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_top
// signed 32-bit integer to decimal ascii text, one character per strobe
// ----------------------------------------------------------------------------
// usage:
//   a value is taken on in_value at a clock edge with start high and busy
//   low. the block then produces its decimal text on out_char_code, one
//   character per out_valid strobe, most significant first: a '-' for
//   negative values, then the digits without leading zeros ('0' for zero).
//   out_last_char marks the final character of the text.
//   each character is shown for exactly one cycle; the receiver takes it
//   at the closing edge and cannot stall the block.
// timing:
//   a '-' appears the cycle after the transfer. the 32-bit magnitude is
//   shifted bit by bit through a row of MAX_DIGITS shift-add-3 digit cells,
//   then the cells shift out one digit a cycle, leading zeros being dropped
//   silently. the last character is shown in the first cycle busy is low
//   again: a new value is not taken until the text of the last one is done.
// reset:
//   rst_n low returns the block to idle and clears the strobe.
// ----------------------------------------------------------------------------
`include "signed_binary_to_decimal_ascii_top_assert.svh"

module signed_binary_to_decimal_ascii_top
  import sbda_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  output logic [CHAR_W-1:0]         out_char_code,
  output logic                      out_last_char
);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t               state_r, state_nxt;
  logic [VALUE_W-1:0]   mag_r, mag_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic                 started_r, started_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  cell_ctrl_t           ctrl;
  logic                 carry [MAX_DIGITS+1];
  logic [DIGIT_W-1:0]   dig   [MAX_DIGITS];
  logic [DIGIT_W-1:0]   din   [MAX_DIGITS];
  logic [VALUE_W-1:0]   uvalue;
  logic [DIGIT_W-1:0]   top_digit;
  logic                 take;
  logic                 show;

  assign uvalue    = in_value;
  assign take      = start && (state_r == ST_IDLE);
  assign top_digit = dig[MAX_DIGITS-1];
  assign show      = started_r || ovf_r || (top_digit != '0) || (rem_r == '0);
  assign carry[0]  = mag_r[VALUE_W-1];

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign din[i] = '0;
    end else begin : g_rest
      assign din[i] = dig[i-1];
    end
    sbda_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (carry[i]),
      .digit_in  (din[i]),
      .bit_out   (carry[i+1]),
      .digit_out (dig[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bit_cnt_nxt   = bit_cnt_r;
    rem_nxt       = rem_r;
    started_nxt   = started_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    ctrl          = '0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          ctrl.clear    = 1'b1;
          mag_nxt       = uvalue[VALUE_W-1] ? (VALUE_W'(0) - uvalue) : uvalue;
          bit_cnt_nxt   = '0;
          ovf_nxt       = 1'b0;
          started_nxt   = 1'b0;
          out_valid_nxt = uvalue[VALUE_W-1];
          out_char_nxt  = CHAR_MINUS;
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv   = 1'b1;
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        ovf_nxt     = ovf_r | carry[MAX_DIGITS];
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(VALUE_W-1)) begin
          rem_nxt   = IDX_W'(MAX_DIGITS-1);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ctrl.shift    = 1'b1;
        out_valid_nxt = show;
        out_char_nxt  = CHAR_ZERO + CHAR_W'(top_digit);
        out_last_nxt  = (rem_r == '0);
        started_nxt   = show;
        rem_nxt       = rem_r - 1'b1;
        if (rem_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      started_r   <= 1'b0;
      ovf_r       <= 1'b0;
      bit_cnt_r   <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      started_r   <= started_nxt;
      ovf_r       <= ovf_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      rem_r       <= rem_nxt;
    end
    mag_r      <= mag_nxt;
    out_char_r <= out_char_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  // end of text returns to idle, earlier characters come while busy
  `SBDA_ASSERT_SAME(a_last_idle, clk, rst_n, out_valid && out_last_char, !busy)
  `SBDA_ASSERT_SAME(a_mid_busy, clk, rst_n, out_valid && !out_last_char, busy)
  `SBDA_ASSERT_NEXT(a_minus_first, clk, rst_n, start && !busy && in_value[VALUE_W-1], out_valid && (out_char_code == CHAR_MINUS) && !out_last_char)

endmodule

### tb/tb_signed_binary_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// tb_signed_binary_to_decimal_ascii_top
// self-checking bench for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
// values are sent over the start/busy command port, first a directed set
// (zero, single digits, powers of ten, both extremes, alternating bit
// patterns), then random values weighted toward every digit count and both
// signs. a scoreboard predicts the character string of each transfer and
// checks every strobed character and its last flag in order. the sender
// pauses at random, with one long stretch that has no pauses at all.
// ----------------------------------------------------------------------------
module tb_signed_binary_to_decimal_ascii_top;
  import sbda_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RAND_ITEMS  = 480;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DEC_RADIX   = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } text_char_t;

  class decimal_text_board;
    text_char_t pending_chars[$];
    int         fails;
    int         chars_seen;
    int         values_noted;
    int         negatives_noted;

    function new();
      fails = 0;
      chars_seen = 0;
      values_noted = 0;
      negatives_noted = 0;
    endfunction

    // expected text of one transferred value
    function void note_value(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digs[MAX_DIGITS];
      text_char_t         c;
      int                 n;
      int                 i;
      values_noted++;
      mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
      n = 0;
      do begin
        digs[n] = DIGIT_W'(mag % DEC_RADIX);
        mag = mag / DEC_RADIX;
        n++;
      end while (mag != 0 && n < MAX_DIGITS);
      if (v[VALUE_W-1]) begin
        negatives_noted++;
        c.char_code = CHAR_MINUS;
        c.last_char = 1'b0;
        pending_chars.push_back(c);
      end
      for (i = n - 1; i >= 0; i--) begin
        c.char_code = CHAR_ZERO + CHAR_W'(digs[i]);
        c.last_char = (i == 0);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      text_char_t exp_c;
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %0d last_char %0d", code, last);
        fails++;
        return;
      end
      exp_c = pending_chars.pop_front();
      if (code !== exp_c.char_code) begin
        $error("char_code mismatch: expected %0d actual %0d", exp_c.char_code, code);
        fails++;
      end
      if (last !== exp_c.last_char) begin
        $error("last_char mismatch: expected %0d actual %0d", exp_c.last_char, last);
        fails++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic [CHAR_W-1:0]         out_char_code;
  logic                      out_last_char;

  decimal_text_board board;
  int                cycles;
  longint            pow10[0:10];

  signed_binary_to_decimal_ascii_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("signed_binary_to_decimal_ascii_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_char(out_char_code, out_last_char);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_value(input logic [VALUE_W-1:0] v);
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    board.note_value(v);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    start    <= 1'b0;
    in_value <= $urandom;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    longint mag;
    int     d;
    case ($urandom_range(3))
      0: mag = $urandom;
      1: begin
        d = $urandom_range(1, 10);
        mag = longint'($urandom) % pow10[d];
      end
      2: begin
        d = $urandom_range(0, 9);
        mag = pow10[d] + $urandom_range(2) - 1;
      end
      default: mag = (64'd1 << 31) - $urandom_range(1);
    endcase
    if ($urandom_range(1)) mag = -mag;
    return mag[VALUE_W-1:0];
  endfunction

  initial begin
    logic [VALUE_W-1:0] directed[$];
    int                 k;
    bit                 quiet;
    board    = new();
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    pow10[0] = 1;
    for (k = 1; k <= 10; k++) pow10[k] = pow10[k-1] * DEC_RADIX;
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 -32'sd100, 32'd1000, 32'd123456789, 32'd999999999, -32'sd999999999,
                 32'd1000000000, 32'h7fffffff, 32'h80000000, 32'h80000001,
                 32'h55555555, 32'haaaaaaaa, 32'hfffffff6, 32'd7, -32'sd5};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_value(directed[i]);
    for (k = 0; k < RAND_ITEMS; k++) begin
      quiet = (k >= 150 && k < 250);
      if (!quiet && $urandom_range(99) < 10) pause_sender($urandom_range(1, 50));
      send_value(random_value());
    end
    start <= 1'b0;
    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("converted %0d values (%0d negative), checked %0d characters",
             board.values_noted, board.negatives_noted, board.chars_seen);
    if (board.fails == 0) begin
      $display("signed_binary_to_decimal_ascii_top verification clean");
    end else begin
      $display("signed_binary_to_decimal_ascii_top verification failed");
    end
    $finish;
  end

endmodule

### signed_binary_to_decimal_ascii_top.f
+incdir+rtl/core
rtl/core/sbda_pkg.sv
rtl/core/sbda_cell.sv
rtl/core/signed_binary_to_decimal_ascii_top.sv
tb/tb_signed_binary_to_decimal_ascii_top.sv
